// ----- rtl/cmr_pkg.sv -----
// Shared types and constants for the CAN multi-frame reassembler.
package cmr_pkg;

	localparam int BUFFER_BYTES_DEF   = 64;
	localparam int OVERHEAD_BYTES_DEF = 3;
	localparam int LANES              = 8;
	localparam int CNT_W              = 7;
	localparam int AW                 = 8;
	localparam int PAYLOAD_OFFSET     = 2;

	localparam logic OP_FRAME     = 1'b0;
	localparam logic OP_LINK_LOST = 1'b1;

	typedef enum logic [1:0] {
		CFG_PAYLOAD_LENGTH = 2'd0,
		CFG_HEADER_BYTE    = 2'd1,
		CFG_TAIL_BYTE      = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic        op;
		logic [3:0]  frame_len;
		logic [63:0] frame_data;
	} in_item_t;

	typedef struct packed {
		logic [63:0] chunk_data;
		logic [3:0]  chunk_bytes;
		logic        last_chunk;
	} out_item_t;

	typedef struct packed {
		logic             receiving;
		logic [CNT_W-1:0] fill;
	} rx_status_t;

endpackage

// ----- rtl/cmr_bank_ram.sv -----
// Message store as eight byte-wide banks with one write and one registered read per bank.
module cmr_bank_ram
	import cmr_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_base,
	input  logic [3:0]    wr_len,
	input  logic [63:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_base,
	output logic [63:0]   rd_data
);

	localparam int ROWS = (BUFFER_BYTES + LANES - 1) / LANES;
	localparam int RW   = $clog2(ROWS);

	for (genvar b = 0; b < LANES; b++) begin : g_bank
		logic [7:0]    mem_q [ROWS];
		logic [7:0]    rd_q;
		logic [2:0]    woff;
		logic [2:0]    roff;
		logic [AW-1:0] waddr;
		logic [AW-1:0] raddr;

		assign woff  = 3'(b) - wr_base[2:0];
		assign roff  = 3'(b) - rd_base[2:0];
		assign waddr = wr_base + AW'(woff);
		assign raddr = rd_base + AW'(roff);

		always_ff @(posedge clk) begin
			if (wr_en && ({1'b0, woff} < wr_len)) begin
				mem_q[waddr[RW+2:3]] <= wr_data[8*woff +: 8];
			end
		end

		always_ff @(posedge clk) begin
			if (rd_en) begin
				rd_q <= mem_q[raddr[RW+2:3]];
			end
		end

		assign rd_data[8*b +: 8] = rd_q;
	end

endmodule

// ----- rtl/cmr_frame_ctrl.sv -----
// Frame intake: start check, append and overrun decision, tail check and store writes.
module cmr_frame_ctrl
	import cmr_pkg::*;
#(
	parameter int OVERHEAD_BYTES = OVERHEAD_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  in_item_t      item,
	input  logic [5:0]    payload_length,
	input  logic [5:0]    pay,
	input  logic [7:0]    header_byte,
	input  logic [7:0]    tail_byte,
	output logic          wr_en,
	output logic [AW-1:0] wr_base,
	output logic [3:0]    wr_len,
	output logic [63:0]   wr_data,
	output logic          emit_start,
	output rx_status_t    status
);

	logic             receiving_q;
	logic [CNT_W-1:0] fill_q;
	logic             receiving_d;
	logic [CNT_W-1:0] fill_d;
	logic [3:0]       len;
	logic [7:0]       b0;
	logic [7:0]       b1;
	logic             active;
	logic [CNT_W-1:0] total;
	logic [CNT_W:0]   sum;
	logic             overrun;
	logic             complete;
	logic [CNT_W-1:0] tail_pos;
	logic [2:0]       tail_idx;
	logic             tail_ok;

	assign len      = (item.frame_len > 4'd8) ? 4'd8 : item.frame_len;
	assign b0       = item.frame_data[7:0];
	assign b1       = item.frame_data[15:8];
	assign active   = receiving_q || (b0 == header_byte && b1 == {2'b00, payload_length});
	assign total    = {1'b0, pay} + CNT_W'(OVERHEAD_BYTES);
	assign sum      = {1'b0, fill_q} + {{(CNT_W-3){1'b0}}, len};
	assign overrun  = sum > {1'b0, total};
	assign complete = sum == {1'b0, total};
	assign tail_pos = total - fill_q - CNT_W'(1);
	assign tail_idx = tail_pos[2:0];
	assign tail_ok  = item.frame_data[8*tail_idx +: 8] == tail_byte;

	assign wr_en      = accept && item.op == OP_FRAME && active && !overrun;
	assign wr_base    = {1'b0, fill_q};
	assign wr_len     = len;
	assign wr_data    = item.frame_data;
	assign emit_start = wr_en && complete && tail_ok && pay != 6'd0;
	assign status     = '{receiving: receiving_q, fill: fill_q};

	always_comb begin
		receiving_d = receiving_q;
		fill_d      = fill_q;
		if (accept) begin
			if (item.op == OP_LINK_LOST) begin
				receiving_d = 1'b0;
				fill_d      = '0;
			end else if (active) begin
				if (overrun || complete) begin
					receiving_d = 1'b0;
					fill_d      = '0;
				end else begin
					receiving_d = 1'b1;
					fill_d      = sum[CNT_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			fill_q      <= '0;
		end else begin
			receiving_q <= receiving_d;
			fill_q      <= fill_d;
		end
	end

endmodule

// ----- rtl/cmr_chunk_out.sv -----
// Payload readout: read sequencer, lane alignment stage and output register.
module cmr_chunk_out
	import cmr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          emit_start,
	input  logic [5:0]    pay,
	output logic          busy,
	output logic          rd_en,
	output logic [AW-1:0] rd_base,
	input  logic [63:0]   rd_data,
	output logic          out_valid,
	input  logic          out_ready,
	output out_item_t     out_data
);

	logic             emit_q;
	logic [CNT_W-1:0] pos_q;
	logic             vld_s1;
	logic [3:0]       n_s1;
	logic             last_s1;
	logic [2:0]       rot_s1;
	logic             out_vld_q;
	out_item_t        out_q;
	logic             adv;
	logic             issue;
	logic [CNT_W-1:0] rem;
	logic [3:0]       n;
	logic             last;
	logic [63:0]      aligned;

	assign adv     = !out_vld_q || out_ready;
	assign issue   = emit_q && (!vld_s1 || adv);
	assign rem     = {1'b0, pay} - pos_q;
	assign last    = rem <= CNT_W'(8);
	assign n       = last ? rem[3:0] : 4'd8;
	assign rd_en   = issue;
	assign rd_base = AW'(pos_q) + AW'(PAYLOAD_OFFSET);
	assign busy    = emit_q;

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			aligned[8*j +: 8] = (4'(j) < n_s1) ? rd_data[8*(3'(rot_s1 + 3'(j))) +: 8] : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q    <= 1'b0;
			pos_q     <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (emit_start) begin
				emit_q <= 1'b1;
				pos_q  <= '0;
			end else if (issue) begin
				pos_q <= pos_q + CNT_W'(8);
				if (last) begin
					emit_q <= 1'b0;
				end
			end
			if (issue) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			n_s1    <= n;
			last_s1 <= last;
			rot_s1  <= rd_base[2:0];
		end
		if (adv && vld_s1) begin
			out_q.chunk_data  <= aligned;
			out_q.chunk_bytes <= n_s1;
			out_q.last_chunk  <= last_s1;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/can_multiframe_reassembler.sv -----
// Top level of the CAN multi-frame reassembler with configuration registers.
//
// Channel   Signals                        Moves
// in        in_valid  in_ready  in_data    one CAN frame or link-lost event
// out       out_valid out_ready out_data   one payload chunk of 1 to 8 bytes
// cfg       cfg_valid cfg_ready cfg_index  one register write, data on cfg_data
//
// A frame transaction is taken every cycle while no readout is running.
// A completing frame with a matching tail starts a readout of ceil(payload/8) chunks,
// one chunk read from the banked store per cycle while output is not stalled; in_ready is low
// until the last read is issued. Each chunk passes the bank read and output registers.
// Reset clears reception and readout, resets configuration; the message store is not cleared.
module can_multiframe_reassembler
	import cmr_pkg::*;
#(
	parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
	parameter int OVERHEAD_BYTES = OVERHEAD_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam logic [7:0] PAY_CAP = 8'(BUFFER_BYTES - OVERHEAD_BYTES);

	logic [5:0]    payload_length_q;
	logic [7:0]    header_byte_q;
	logic [7:0]    tail_byte_q;
	logic [5:0]    pay;
	logic          accept;
	logic          wr_en;
	logic [AW-1:0] wr_base;
	logic [3:0]    wr_len;
	logic [63:0]   wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_base;
	logic [63:0]   rd_data;
	logic          emit_start;
	logic          busy;
	rx_status_t    status;

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy;
	assign accept    = in_valid && in_ready;
	assign pay       = ({2'b00, payload_length_q} > PAY_CAP) ? PAY_CAP[5:0] : payload_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_length_q <= 6'd8;
			header_byte_q    <= 8'h00;
			tail_byte_q      <= 8'h00;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PAYLOAD_LENGTH: payload_length_q <= cfg_data[5:0];
				CFG_HEADER_BYTE:    header_byte_q    <= cfg_data;
				CFG_TAIL_BYTE:      tail_byte_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cmr_frame_ctrl #(
		.OVERHEAD_BYTES(OVERHEAD_BYTES)
	) u_frame_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.item          (in_data),
		.payload_length(payload_length_q),
		.pay           (pay),
		.header_byte   (header_byte_q),
		.tail_byte     (tail_byte_q),
		.wr_en         (wr_en),
		.wr_base       (wr_base),
		.wr_len        (wr_len),
		.wr_data       (wr_data),
		.emit_start    (emit_start),
		.status        (status)
	);

	cmr_bank_ram #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_bank_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_base(wr_base),
		.wr_len (wr_len),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_base(rd_base),
		.rd_data(rd_data)
	);

	cmr_chunk_out u_chunk_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit_start(emit_start),
		.pay       (pay),
		.busy      (busy),
		.rd_en     (rd_en),
		.rd_base   (rd_base),
		.rd_data   (rd_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_start_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		emit_start |-> accept && !busy)
		else $error("Readout started without an accepted frame transaction.");

	a_chunk_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.chunk_bytes != 4'd0 && out_data.chunk_bytes <= 4'd8)
		else $error("Chunk byte count out of range.");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!status.receiving |-> status.fill == '0)
		else $error("Fill count is nonzero while reception is idle.");

	a_no_write_in_readout: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !wr_en)
		else $error("Store written while a payload readout is running.");

endmodule
